// ===== rtl/sjfk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfk_pkg: shared types, constants and fixed-point helpers
// Word types, CORDIC constants, register indexes and the rounding product.
// ----------------------------------------------------------------------------
package sjfk_pkg;

	typedef logic signed [31:0] trig_t;
	typedef logic signed [39:0] vw_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  idx;
		logic [31:0] val;
	} tool_wr_t;

	localparam logic [1:0] REG_D1 = 2'd0;
	localparam logic [1:0] REG_D3 = 2'd1;
	localparam logic [1:0] REG_D5 = 2'd2;
	localparam logic [1:0] REG_D7 = 2'd3;

	localparam int CORDIC_STEPS = 30;
	// lane: two reduction stages, the rotation steps, one output stage
	localparam int LANE_LAT     = CORDIC_STEPS + 3;
	localparam int POSE_LAT     = 6;
	localparam int META_LAT     = LANE_LAT + POSE_LAT;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_34      = 34'sd1073741824;
	localparam vw_t ONE_VW  = 40'sd1073741824;
	localparam vw_t QLIM_VW = 40'sd2147483648;

	localparam int ATAN_Q30 [CORDIC_STEPS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 8, 4, 2
	};

	function automatic vw_t wide(input trig_t v);
		return vw_t'(v);
	endfunction

	// Rounded Q30 product with both operands limited to +-2^31.
	function automatic vw_t qmul(input vw_t a, input vw_t b);
		logic signed [32:0] ca;
		logic signed [32:0] cb;
		logic signed [65:0] p;
		if (a > QLIM_VW)       ca = 33'sd2147483648;
		else if (a < -QLIM_VW) ca = -33'sd2147483648;
		else                   ca = a[32:0];
		if (b > QLIM_VW)       cb = 33'sd2147483648;
		else if (b < -QLIM_VW) cb = -33'sd2147483648;
		else                   cb = b[32:0];
		p = 66'(ca) * 66'(cb);
		p = p + 66'sd536870912;
		p = p >>> 30;
		return p[39:0];
	endfunction

	function automatic vw_t clamp_rot(input vw_t v);
		if (v > ONE_VW)       return ONE_VW;
		else if (v < -ONE_VW) return -ONE_VW;
		else                  return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sjfk_cordic_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfk_cordic_lane: sine and cosine of one joint angle
// Two range-reduction stages, one register per rotation step, output clamp.
// ----------------------------------------------------------------------------
module sjfk_cordic_lane
	import sjfk_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire trig_t angle,
	output trig_t     sin_val,
	output trig_t     cos_val
);

	logic signed [35:0] z_dbl;
	logic signed [35:0] z_wrap;
	logic signed [35:0] zr_s1;
	logic signed [35:0] z_fold;
	logic               flip_fold;
	logic signed [33:0] zf_s2;
	logic               flip_s2;

	logic signed [33:0] x_sk [CORDIC_STEPS];
	logic signed [33:0] y_sk [CORDIC_STEPS];
	logic signed [33:0] z_sk [CORDIC_STEPS];
	logic               flip_sk [CORDIC_STEPS];

	logic signed [33:0] x_fin;
	logic signed [33:0] y_fin;

	always_comb begin
		z_dbl = {{3{angle[31]}}, angle, 1'b0};
		if (z_dbl > PI_Q30)       z_wrap = z_dbl - TWO_PI_Q30;
		else if (z_dbl < -PI_Q30) z_wrap = z_dbl + TWO_PI_Q30;
		else                      z_wrap = z_dbl;
	end

	always_ff @(posedge clk) begin
		if (en) zr_s1 <= z_wrap;
	end

	always_comb begin
		flip_fold = 1'b1;
		if (zr_s1 > HALF_PI_Q30)       z_fold = zr_s1 - PI_Q30;
		else if (zr_s1 < -HALF_PI_Q30) z_fold = zr_s1 + PI_Q30;
		else begin
			z_fold    = zr_s1;
			flip_fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zf_s2   <= z_fold[33:0];
			flip_s2 <= flip_fold;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [33:0] xi, yi, zi, dx, dy;
		logic               fi;
		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = zf_s2;
			assign fi = flip_s2;
		end else begin : g_next
			assign xi = x_sk[i-1];
			assign yi = y_sk[i-1];
			assign zi = z_sk[i-1];
			assign fi = flip_sk[i-1];
		end
		assign dx = yi >>> i;
		assign dy = xi >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				flip_sk[i] <= fi;
				if (zi >= 0) begin
					x_sk[i] <= xi - dx;
					y_sk[i] <= yi + dy;
					z_sk[i] <= zi - 34'(ATAN_Q30[i]);
				end else begin
					x_sk[i] <= xi + dx;
					y_sk[i] <= yi - dy;
					z_sk[i] <= zi + 34'(ATAN_Q30[i]);
				end
			end
		end
	end

	always_comb begin
		x_fin = flip_sk[CORDIC_STEPS-1] ? -x_sk[CORDIC_STEPS-1] : x_sk[CORDIC_STEPS-1];
		y_fin = flip_sk[CORDIC_STEPS-1] ? -y_sk[CORDIC_STEPS-1] : y_sk[CORDIC_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (x_fin > ONE_34)       cos_val <= 32'sd1073741824;
			else if (x_fin < -ONE_34) cos_val <= -32'sd1073741824;
			else                      cos_val <= x_fin[31:0];
			if (y_fin > ONE_34)       sin_val <= 32'sd1073741824;
			else if (y_fin < -ONE_34) sin_val <= -32'sd1073741824;
			else                      sin_val <= y_fin[31:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sjfk_pose.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfk_pose: closed-form flange pose
// Merges the seven lanes' sines and cosines in six product levels.
// ----------------------------------------------------------------------------
module sjfk_pose
	import sjfk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire trig_t       sn [7],
	input  wire trig_t       cs [7],
	input  wire logic [27:0] d1,
	input  wire logic [27:0] d3,
	input  wire logic [27:0] d5,
	input  wire logic [27:0] d7,
	output vw_t              tm [3][4]
);

	vw_t dd1, dd3, dd5, dd7;
	assign dd1 = vw_t'({12'd0, d1});
	assign dd3 = vw_t'({12'd0, d3});
	assign dd5 = vw_t'({12'd0, d5});
	assign dd7 = vw_t'({12'd0, d7});

	vw_t s_s1 [7], c_s1 [7], s_s2 [7], c_s2 [7], s_s3 [7], c_s3 [7];
	vw_t s_s4 [7], c_s4 [7], s_s5 [7], c_s5 [7];

	vw_t c1s2_s1, s1s2_s1, s2s3_s1, s0s2_s1, cc01_s1, c2s0_s1, c0c3_s1, c0s2_s1;
	vw_t cc12_s1, c0c2_s1, cs10_s1, c3s0_s1, c1s3_s1, c2c3_s1, c1c3_s1, c2s1_s1;
	vw_t a0_s2, b0_s2, x0_s2, a1_s2, b1_s2, y1_s2, p2_s2, q2_s2;
	vw_t c1s2_s2, s1s2_s2, s2s3_s2;
	vw_t p0_s3, q0_s3, b0_s3, q1_s3, p1_s3, b1_s3, r2_s3, u2_s3, q2_s3;
	vw_t c1s2_s3, s1s2_s3;
	vw_t r0_s4, u0_s4, q0_s4, r1_s4, u1_s4, q1_s4, v2_s4, t22_s4, u2_s4, pq2_s4;
	vw_t c1s2_s4, s1s2_s4;
	vw_t v0_s5, t02_s5, u0_s5, pq0_s5, v1_s5, t12_s5, u1_s5, pq1_s5;
	vw_t t20_s5, t21_s5, t22_s5, t23_s5, c1s2_s5, s1s2_s5;

	// level 1: products of two trig values
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 7; k++) begin
				s_s1[k] <= wide(sn[k]);
				c_s1[k] <= wide(cs[k]);
			end
			c1s2_s1 <= qmul(wide(cs[0]), wide(sn[1]));
			s1s2_s1 <= qmul(wide(sn[0]), wide(sn[1]));
			s2s3_s1 <= qmul(wide(sn[1]), wide(sn[2]));
			s0s2_s1 <= qmul(wide(sn[0]), wide(sn[2]));
			cc01_s1 <= qmul(wide(cs[0]), wide(cs[1]));
			c2s0_s1 <= qmul(wide(cs[2]), wide(sn[0]));
			c0c3_s1 <= qmul(wide(cs[0]), wide(cs[3]));
			c0s2_s1 <= qmul(wide(cs[0]), wide(sn[2]));
			cc12_s1 <= qmul(wide(cs[1]), wide(cs[2]));
			c0c2_s1 <= qmul(wide(cs[0]), wide(cs[2]));
			cs10_s1 <= qmul(wide(cs[1]), wide(sn[0]));
			c3s0_s1 <= qmul(wide(cs[3]), wide(sn[0]));
			c1s3_s1 <= qmul(wide(cs[1]), wide(sn[3]));
			c2c3_s1 <= qmul(wide(cs[2]), wide(cs[3]));
			c1c3_s1 <= qmul(wide(cs[1]), wide(cs[3]));
			c2s1_s1 <= qmul(wide(cs[2]), wide(sn[1]));
		end
	end

	// level 2
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= s_s1;
			c_s2 <= c_s1;
			a0_s2 <= s0s2_s1 - qmul(cc01_s1, c_s1[2]);
			b0_s2 <= c2s0_s1 + qmul(cc01_s1, s_s1[2]);
			x0_s2 <= qmul(c0c3_s1, s_s1[1]);
			a1_s2 <= c0s2_s1 + qmul(cc12_s1, s_s1[0]);
			b1_s2 <= c0c2_s1 - qmul(cs10_s1, s_s1[2]);
			y1_s2 <= qmul(c3s0_s1, s_s1[1]);
			p2_s2 <= c1s3_s1 - qmul(c2c3_s1, s_s1[1]);
			q2_s2 <= c1c3_s1 + qmul(c2s1_s1, s_s1[3]);
			c1s2_s2 <= c1s2_s1;
			s1s2_s2 <= s1s2_s1;
			s2s3_s2 <= s2s3_s1;
		end
	end

	// level 3
	always_ff @(posedge clk) begin
		if (en) begin
			s_s3 <= s_s2;
			c_s3 <= c_s2;
			p0_s3 <= qmul(c_s2[3], a0_s2) - qmul(c1s2_s2, s_s2[3]);
			q0_s3 <= qmul(s_s2[3], a0_s2) + x0_s2;
			b0_s3 <= b0_s2;
			q1_s3 <= qmul(s_s2[3], a1_s2) - y1_s2;
			p1_s3 <= qmul(c_s2[3], a1_s2) + qmul(s1s2_s2, s_s2[3]);
			b1_s3 <= b1_s2;
			r2_s3 <= qmul(c_s2[4], p2_s2) + qmul(s2s3_s2, s_s2[4]);
			u2_s3 <= qmul(s_s2[4], p2_s2) - qmul(c_s2[4], s2s3_s2);
			q2_s3 <= q2_s2;
			c1s2_s3 <= c1s2_s2;
			s1s2_s3 <= s1s2_s2;
		end
	end

	// level 4
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= s_s3;
			c_s4 <= c_s3;
			r0_s4 <= qmul(c_s3[4], p0_s3) + qmul(s_s3[4], b0_s3);
			u0_s4 <= qmul(s_s3[4], p0_s3) - qmul(c_s3[4], b0_s3);
			q0_s4 <= q0_s3;
			r1_s4 <= qmul(c_s3[4], p1_s3) + qmul(s_s3[4], b1_s3);
			u1_s4 <= qmul(s_s3[4], p1_s3) - qmul(c_s3[4], b1_s3);
			q1_s4 <= q1_s3;
			v2_s4 <= qmul(c_s3[5], r2_s3) - qmul(s_s3[5], q2_s3);
			t22_s4 <= qmul(s_s3[5], r2_s3) + qmul(c_s3[5], q2_s3);
			u2_s4 <= u2_s3;
			pq2_s4 <= qmul(dd5, q2_s3);
			c1s2_s4 <= c1s2_s3;
			s1s2_s4 <= s1s2_s3;
		end
	end

	// level 5
	always_ff @(posedge clk) begin
		if (en) begin
			s_s5 <= s_s4;
			c_s5 <= c_s4;
			v0_s5 <= qmul(s_s4[5], q0_s4) + qmul(c_s4[5], r0_s4);
			t02_s5 <= qmul(c_s4[5], q0_s4) - qmul(s_s4[5], r0_s4);
			u0_s5 <= u0_s4;
			pq0_s5 <= qmul(dd5, q0_s4);
			v1_s5 <= qmul(s_s4[5], q1_s4) + qmul(c_s4[5], r1_s4);
			t12_s5 <= qmul(s_s4[5], r1_s4) - qmul(c_s4[5], q1_s4);
			u1_s5 <= u1_s4;
			pq1_s5 <= qmul(dd5, q1_s4);
			t20_s5 <= qmul(c_s4[6], v2_s4) - qmul(s_s4[6], u2_s4);
			t21_s5 <= -qmul(c_s4[6], u2_s4) - qmul(s_s4[6], v2_s4);
			t22_s5 <= t22_s4;
			t23_s5 <= dd1 + pq2_s4 + qmul(dd7, t22_s4) + qmul(dd3, c_s4[1]);
			c1s2_s5 <= c1s2_s4;
			s1s2_s5 <= s1s2_s4;
		end
	end

	// level 6: last products, rotation entries clamped for the tool product
	always_ff @(posedge clk) begin
		if (en) begin
			tm[0][0] <= clamp_rot(qmul(s_s5[6], u0_s5) - qmul(c_s5[6], v0_s5));
			tm[0][1] <= clamp_rot(qmul(c_s5[6], u0_s5) + qmul(s_s5[6], v0_s5));
			tm[0][2] <= clamp_rot(t02_s5);
			tm[0][3] <= qmul(dd7, t02_s5) + pq0_s5 + qmul(dd3, c1s2_s5);
			tm[1][0] <= clamp_rot(qmul(c_s5[6], v1_s5) - qmul(s_s5[6], u1_s5));
			tm[1][1] <= clamp_rot(-qmul(c_s5[6], u1_s5) - qmul(s_s5[6], v1_s5));
			tm[1][2] <= clamp_rot(t12_s5);
			tm[1][3] <= qmul(dd3, s1s2_s5) - pq1_s5 - qmul(dd7, t12_s5);
			tm[2][0] <= clamp_rot(t20_s5);
			tm[2][1] <= clamp_rot(t21_s5);
			tm[2][2] <= clamp_rot(t22_s5);
			tm[2][3] <= t23_s5;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sjfk_tool.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfk_tool: tool transform store and tool product
// Holds the 3x4 tool words; one product level, then sum, round and saturate.
// ----------------------------------------------------------------------------
module sjfk_tool
	import sjfk_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire tool_wr_t wr,
	input  wire vw_t      tm [3][4],
	output trig_t         res [12]
);

	trig_t tool_q [12];
	logic signed [63:0] prod_s1 [3][4][3];
	vw_t                tpos_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 12; k++)
				tool_q[k] <= (k == 0 || k == 5 || k == 10) ? 32'sd1073741824 : 32'sd0;
		end else if (en && wr.en) begin
			tool_q[wr.idx] <= wr.val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tpos_s1[i] <= tm[i][3];
				for (int j = 0; j < 4; j++)
					for (int k = 0; k < 3; k++)
						prod_s1[i][j][k] <= 64'(trig_t'(tm[i][k][31:0]))
							* 64'(tool_q[k*4+j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [65:0] acc;
		logic signed [40:0] sum;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) begin
					acc = 66'(prod_s1[i][j][0]) + 66'(prod_s1[i][j][1])
						+ 66'(prod_s1[i][j][2]) + 66'sd536870912;
					acc = acc >>> 30;
					if (j == 3) begin
						sum = 41'(vw_t'(acc[39:0])) + 41'(tpos_s1[i]);
						if (sum > 41'sd2147483647)       res[i*4+j] <= 32'h7fffffff;
						else if (sum < -41'sd2147483648) res[i*4+j] <= 32'h80000000;
						else                             res[i*4+j] <= sum[31:0];
					end else begin
						res[i*4+j] <= trig_t'(clamp_rot(acc[39:0]));
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/seven_joint_forward_kinematics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_joint_forward_kinematics: tool pose of a seven-axis serial arm
// Seven CORDIC lanes, a six-level pose merge and a tool transform product.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | kind, tool_index, tool_value, angle_j1..7
//  output  | out_valid/ out_ready | rot_xx .. pos_z (three pose rows)
//  config  | cfg_we               | cfg_index, cfg_data (link lengths)
//
// One item is taken per cycle while the output is not stalled; a pose passes
// 33 CORDIC lane stages, 6 pose levels and 2 tool product stages on its way out.
// Load items travel down the same pipeline and write the tool store as they
// pass the tool product, so they act in order with the poses around them.
// A stalled output holds the whole pipeline: in_ready falls with it.
// Reset empties the pipeline, clears the link lengths and sets the tool
// transform to identity.
// ----------------------------------------------------------------------------
module seven_joint_forward_kinematics
	import sjfk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [27:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [3:0]  tool_index,
	input  wire trig_t       tool_value,
	input  wire trig_t       angle_j1,
	input  wire trig_t       angle_j2,
	input  wire trig_t       angle_j3,
	input  wire trig_t       angle_j4,
	input  wire trig_t       angle_j5,
	input  wire trig_t       angle_j6,
	input  wire trig_t       angle_j7,
	output logic             out_valid,
	input  wire logic        out_ready,
	output trig_t            rot_xx,
	output trig_t            rot_xy,
	output trig_t            rot_xz,
	output trig_t            pos_x,
	output trig_t            rot_yx,
	output trig_t            rot_yy,
	output trig_t            rot_yz,
	output trig_t            pos_y,
	output trig_t            rot_zx,
	output trig_t            rot_zy,
	output trig_t            rot_zz,
	output trig_t            pos_z
);

	logic [27:0] d1_q, d3_q, d5_q, d7_q;

	// The whole pipeline moves whenever the output register can take a word.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d3_q <= '0;
			d5_q <= '0;
			d7_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_D1: d1_q <= cfg_data;
				REG_D3: d3_q <= cfg_data;
				REG_D5: d5_q <= cfg_data;
				REG_D7: d7_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item details run alongside the lanes and the pose levels.
	logic        vld_q  [META_LAT];
	logic        kind_q [META_LAT];
	logic [3:0]  idx_q  [META_LAT];
	trig_t       val_q  [META_LAT];
	logic        prod_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < META_LAT; k++)
				vld_q[k] <= 1'b0;
			prod_vld_q <= 1'b0;
			out_valid  <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < META_LAT; k++)
				vld_q[k] <= vld_q[k-1];
			prod_vld_q <= vld_q[META_LAT-1] && kind_q[META_LAT-1];
			out_valid  <= prod_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q[0] <= kind;
			idx_q[0]  <= tool_index;
			val_q[0]  <= tool_value;
			for (int k = 1; k < META_LAT; k++) begin
				kind_q[k] <= kind_q[k-1];
				idx_q[k]  <= idx_q[k-1];
				val_q[k]  <= val_q[k-1];
			end
		end
	end

	trig_t angles [7];
	trig_t sn [7];
	trig_t cs [7];
	assign angles = '{angle_j1, angle_j2, angle_j3, angle_j4, angle_j5, angle_j6, angle_j7};

	for (genvar j = 0; j < 7; j++) begin : g_lane
		sjfk_cordic_lane u_lane (
			.clk     (clk),
			.en      (adv),
			.angle   (angles[j]),
			.sin_val (sn[j]),
			.cos_val (cs[j])
		);
	end

	vw_t tm [3][4];

	sjfk_pose u_pose (
		.clk (clk),
		.en  (adv),
		.sn  (sn),
		.cs  (cs),
		.d1  (d1_q),
		.d3  (d3_q),
		.d5  (d5_q),
		.d7  (d7_q),
		.tm  (tm)
	);

	// A load whose index lies beyond the twelve tool words is dropped.
	tool_wr_t wr;
	always_comb begin
		wr.en  = vld_q[META_LAT-1] && !kind_q[META_LAT-1] && (idx_q[META_LAT-1] < 4'd12);
		wr.idx = idx_q[META_LAT-1];
		wr.val = val_q[META_LAT-1];
	end

	trig_t res [12];

	sjfk_tool u_tool (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.wr     (wr),
		.tm     (tm),
		.res    (res)
	);

	assign rot_xx = res[0];
	assign rot_xy = res[1];
	assign rot_xz = res[2];
	assign pos_x  = res[3];
	assign rot_yx = res[4];
	assign rot_yy = res[5];
	assign rot_yz = res[6];
	assign pos_y  = res[7];
	assign rot_zx = res[8];
	assign rot_zy = res[9];
	assign rot_zz = res[10];
	assign pos_z  = res[11];

endmodule
`default_nettype wire

// ===== rtl/sjfk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjfk_checker: port-level checks for the forward kinematics block
// Watches the handshakes and result ranges; bound to the top level.
// ----------------------------------------------------------------------------
module sjfk_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] rot_xx,
	input wire logic [31:0] rot_zz
);

	// a held result keeps its rot_xx word until it is transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rot_xx))
		else $error("held result changed");

	// an empty output stage never refuses input
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	// a stalled output stalls the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");

	// rot_xx and rot_zz stay within plus and minus one while a result is valid
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(rot_xx) <= 32'sd1073741824)
			&& ($signed(rot_xx) >= -32'sd1073741824)
			&& ($signed(rot_zz) <= 32'sd1073741824)
			&& ($signed(rot_zz) >= -32'sd1073741824))
		else $error("rotation word out of range");

endmodule

bind seven_joint_forward_kinematics sjfk_checker u_sjfk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.rot_xx    (rot_xx),
	.rot_zz    (rot_zz)
);
`default_nettype wire
